[src/pcxd_pkg.sv]
// Shared types, constants and helpers for the PCX planar run-length decoder.
`default_nettype none

package pcxd_pkg;

  localparam int MaxPlanes    = 4;
  localparam int MaxLineBytes = 4096;
  localparam int MaxRows      = 4096;

  localparam int PlaneCfgW = 3;
  localparam int LineW     = 13;
  localparam int RowW      = 13;
  localparam int PlaneIdxW = 2;
  localparam int RowIdxW   = 12;
  localparam int CountW    = 6;
  localparam int OffW      = 15;
  localparam int AddrW     = 26;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 13;

  localparam logic [7:0] RunMark   = 8'hC0;
  localparam logic [7:0] CountMask = 8'h3F;

  localparam logic [CfgIdxW-1:0] RegPlaneCount   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBytesPerLine = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRowCount     = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0] pixel_address;
    logic [7:0]       pixel_value;
    logic             last;
    logic             image_done;
    logic             run_clipped;
  } out_item_t;

  typedef struct packed {
    logic cfg_write;
    logic accept;
    logic set_pending;
    logic clear_pending;
    logic start_run;
    logic emit_literal;
    logic emit_run;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic skip;
    logic pending;
    logic header;
    logic zero_run;
    logic run_last;
  } dp_status_t;

  function automatic logic [PlaneCfgW-1:0] clamp_planes(input logic [PlaneCfgW-1:0] v);
    logic [PlaneCfgW-1:0] r;
    r = v;
    if (v == '0) begin
      r = PlaneCfgW'(1);
    end else if (v > PlaneCfgW'(MaxPlanes)) begin
      r = PlaneCfgW'(MaxPlanes);
    end
    return r;
  endfunction

  function automatic logic [LineW-1:0] clamp_len(input logic [LineW-1:0] v,
                                                 input logic [LineW-1:0] hi);
    logic [LineW-1:0] r;
    r = v;
    if (v == '0) begin
      r = LineW'(1);
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/pcxd_ctrl.sv]
// Sequencer for the PCX decoder: takes requests and steps through run output.
`default_nettype none

module pcxd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  pcxd_pkg::dp_status_t st,
  output pcxd_pkg::ctrl_cmd_t  cmd
);

  pcxd_pkg::state_t state;
  pcxd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcxd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    cfg_ready  = 1'b0;
    unique case (state)
      pcxd_pkg::ST_IDLE: begin
        cfg_ready     = 1'b1;
        // register writes take precedence over requests
        in_stall      = !st.out_free || cfg_valid;
        cmd.cfg_write = cfg_valid;
        if (in_valid && st.out_free && !cfg_valid) begin
          cmd.accept = 1'b1;
          priority if (st.skip) begin
          end else if (st.pending) begin
            cmd.clear_pending = 1'b1;
            if (!st.zero_run) begin
              cmd.start_run = 1'b1;
              state_next    = pcxd_pkg::ST_RUN;
            end
          end else if (st.header) begin
            cmd.set_pending = 1'b1;
          end else begin
            cmd.emit_literal = 1'b1;
          end
        end
      end
      pcxd_pkg::ST_RUN: begin
        if (st.out_free) begin
          cmd.emit_run = 1'b1;
          if (st.run_last) begin
            state_next = pcxd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = pcxd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/pcxd_dp.sv]
// Datapath for the PCX decoder: registers, position walk, addressing, output stage.
`default_nettype none

module pcxd_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pcxd_pkg::ctrl_cmd_t                   cmd,
  output pcxd_pkg::dp_status_t                  st,
  input  pcxd_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output pcxd_pkg::out_item_t                   out_data,
  input  logic [pcxd_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [pcxd_pkg::CfgDataW-1:0]         cfg_data
);

  localparam int LineW  = pcxd_pkg::LineW;
  localparam int RowW   = pcxd_pkg::RowW;
  localparam int PlW    = pcxd_pkg::PlaneCfgW;
  localparam int OffW   = pcxd_pkg::OffW;
  localparam int AddrW  = pcxd_pkg::AddrW;
  localparam int CountW = pcxd_pkg::CountW;

  // clamped configuration
  logic [PlW-1:0]   pc;
  logic [LineW-1:0] bpl;
  logic [RowW-1:0]  rows;

  // position and run state
  logic [LineW-1:0]              col;
  logic [pcxd_pkg::PlaneIdxW-1:0] plane;
  logic [pcxd_pkg::RowIdxW-1:0]   row;
  logic [OffW-1:0]               col_off;
  logic [AddrW-1:0]              row_base;
  logic                          pending;
  logic [CountW-1:0]             pend_cnt;
  logic                          done;
  logic [CountW-1:0]             run_cnt;
  logic [7:0]                    run_value;
  logic                          run_clip;

  logic                          restart_now;
  logic [LineW-1:0]              col_cur;
  logic [pcxd_pkg::PlaneIdxW-1:0] plane_cur;
  logic [pcxd_pkg::RowIdxW-1:0]   row_cur;
  logic [OffW-1:0]               col_off_cur;
  logic [AddrW-1:0]              row_base_cur;
  logic                          done_cur;
  logic                          pending_cur;

  logic [OffW-1:0]   stride;
  logic [LineW-1:0]  col_inc;
  logic [PlW-1:0]    plane_inc;
  logic [RowW-1:0]   row_inc;
  logic              col_wrap;
  logic              plane_wrap;
  logic              row_wrap;
  logic              fin;
  logic              emit;
  logic [LineW-1:0]  remain;
  logic              clipped;
  logic [CountW-1:0] emit_cnt;
  logic              out_free;

  assign stride = OffW'(pc) * OffW'(bpl);

  assign restart_now  = cmd.accept && in_data.restart;
  assign col_cur      = restart_now ? '0 : col;
  assign plane_cur    = restart_now ? '0 : plane;
  assign row_cur      = restart_now ? '0 : row;
  assign col_off_cur  = restart_now ? '0 : col_off;
  assign row_base_cur = restart_now ? '0 : row_base;
  assign done_cur     = restart_now ? 1'b0 : done;
  assign pending_cur  = restart_now ? 1'b0 : pending;

  assign col_inc    = col_cur + LineW'(1);
  assign plane_inc  = {1'b0, plane_cur} + PlW'(1);
  assign row_inc    = {1'b0, row_cur} + RowW'(1);
  assign col_wrap   = (col_inc == bpl);
  assign plane_wrap = (plane_inc == pc);
  assign row_wrap   = (row_inc == rows);
  assign fin        = col_wrap && plane_wrap && row_wrap;
  assign emit       = cmd.emit_literal || cmd.emit_run;

  assign remain   = bpl - col;
  assign clipped  = LineW'(pend_cnt) > remain;
  assign emit_cnt = clipped ? remain[CountW-1:0] : pend_cnt;

  assign out_free = !out_valid || !out_stall;

  assign st.out_free = out_free;
  assign st.skip     = !in_data.restart && done;
  assign st.pending  = !in_data.restart && pending;
  assign st.header   = ((in_data.code_byte & pcxd_pkg::RunMark) == pcxd_pkg::RunMark);
  assign st.zero_run = (pend_cnt == '0);
  assign st.run_last = (run_cnt == CountW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= PlW'(3);
      bpl      <= LineW'(1);
      rows     <= RowW'(1);
      col      <= '0;
      plane    <= '0;
      row      <= '0;
      col_off  <= '0;
      row_base <= '0;
      pending  <= 1'b0;
      pend_cnt <= '0;
      done     <= 1'b0;
      run_cnt  <= '0;
    end else if (cmd.cfg_write) begin
      unique case (cfg_index)
        pcxd_pkg::RegPlaneCount:   pc   <= pcxd_pkg::clamp_planes(cfg_data[PlW-1:0]);
        pcxd_pkg::RegBytesPerLine: bpl  <= pcxd_pkg::clamp_len(cfg_data,
                                             LineW'(pcxd_pkg::MaxLineBytes));
        pcxd_pkg::RegRowCount:     rows <= pcxd_pkg::clamp_len(cfg_data,
                                             LineW'(pcxd_pkg::MaxRows));
        default: ;
      endcase
      if (cfg_index == pcxd_pkg::RegPlaneCount || cfg_index == pcxd_pkg::RegBytesPerLine
          || cfg_index == pcxd_pkg::RegRowCount) begin
        col      <= '0;
        plane    <= '0;
        row      <= '0;
        col_off  <= '0;
        row_base <= '0;
        pending  <= 1'b0;
        pend_cnt <= '0;
        done     <= 1'b0;
      end
    end else begin
      col      <= col_cur;
      plane    <= plane_cur;
      row      <= row_cur;
      col_off  <= col_off_cur;
      row_base <= row_base_cur;
      done     <= done_cur;
      pending  <= pending_cur;
      if (restart_now) begin
        pend_cnt <= '0;
      end
      if (cmd.set_pending) begin
        pending  <= 1'b1;
        pend_cnt <= in_data.code_byte[CountW-1:0] & pcxd_pkg::CountMask[CountW-1:0];
      end else if (cmd.clear_pending) begin
        pending  <= 1'b0;
        pend_cnt <= '0;
      end
      if (cmd.start_run) begin
        run_cnt <= emit_cnt;
      end else if (cmd.emit_run) begin
        run_cnt <= run_cnt - CountW'(1);
      end
      if (emit) begin
        if (!col_wrap) begin
          col     <= col_inc;
          col_off <= col_off_cur + OffW'(pc);
        end else begin
          col     <= '0;
          col_off <= '0;
          if (!plane_wrap) begin
            plane <= plane_inc[pcxd_pkg::PlaneIdxW-1:0];
          end else begin
            plane <= '0;
            if (!row_wrap) begin
              row      <= row_inc[pcxd_pkg::RowIdxW-1:0];
              row_base <= row_base_cur + AddrW'(stride);
            end else begin
              row      <= '0;
              row_base <= '0;
              done     <= 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_run) begin
      run_value <= in_data.code_byte;
      run_clip  <= clipped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.pixel_address <= row_base_cur + AddrW'(plane_cur) + AddrW'(col_off_cur);
      out_data.pixel_value   <= cmd.emit_run ? run_value : in_data.code_byte;
      out_data.last          <= cmd.emit_run ? (run_cnt == CountW'(1)) : 1'b1;
      out_data.image_done    <= fin;
      out_data.run_clipped   <= cmd.emit_run ? run_clip : 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_col_in_line: assert property (@(posedge clk) disable iff (rst) col < bpl)
    else $error("column walked past line end");
  a_plane_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, plane} < pc)
    else $error("plane index out of range");
  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    RowW'(row) < rows)
    else $error("row index out of range");
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_run |-> run_cnt != '0)
    else $error("run output with empty counter");
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.image_done |-> out_data.last)
    else $error("image end not on final pixel of request");
`endif

endmodule

`default_nettype wire

[src/pcx_rle_planar_decoder.sv]
// Top level of the PCX run-length decoder with plane-interleaved addressing.
`default_nettype none

// Decodes a PCX run-length byte stream into pixel bytes with their addresses in a
// plane-interleaved buffer. Each input request is one coded byte. A literal byte, a run
// header or a byte swallowed after image end is taken while the output register is free or
// being drained; a run value byte that yields N pixels holds the input stalled while the
// single output register delivers one pixel per cycle, as long as the output is not
// stalled. Runs are clipped at the end of the plane line. Once the image is complete,
// further bytes are swallowed until a restart request or a register write. Registers
// are clamped to their legal ranges when written and may be written only while idle;
// a register write offered in the same cycle as a request holds the request off for
// that cycle.
module pcx_rle_planar_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pcxd_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pcxd_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcxd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pcxd_pkg::CfgDataW-1:0] cfg_data
);

  pcxd_pkg::ctrl_cmd_t  cmd;
  pcxd_pkg::dp_status_t st;

  pcxd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .st        (st),
    .cmd       (cmd)
  );

  pcxd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire
